// ----- rtl/core/dsp_pkg.sv -----
// ----------------------------------------------------------------------------
// dsp_pkg
// Shared types, constants and the band lookup for the dual servo pulse
// generator.
// ----------------------------------------------------------------------------
`default_nettype none

package dsp_pkg;

	typedef enum logic [1:0] {
		OP_SAMPLE     = 2'd0,
		OP_FAST_TICK  = 2'd1,
		OP_FRAME_TICK = 2'd2
	} op_t;

	localparam int BAND_COUNT = 11;

	typedef logic [7:0] duty_t;
	typedef logic [3:0] len_t;
	typedef logic [7:0] count_t;
	typedef logic [1:0] chan_t;

	localparam duty_t DUTY_OFFSET_RST = 8'd124;
	localparam duty_t DUTY_RST        = 8'd15;

	localparam chan_t CHAN_DUTY_A = 2'd0;
	localparam chan_t CHAN_DUTY_B = 2'd1;
	localparam chan_t CHAN_LEN_A  = 2'd2;
	localparam chan_t CHAN_LEN_B  = 2'd3;

	localparam logic [7:0] BAND_LIMIT [BAND_COUNT] = '{
		8'd19, 8'd40, 8'd61, 8'd82, 8'd103, 8'd131,
		8'd152, 8'd173, 8'd194, 8'd215, 8'd236
	};

	localparam len_t BAND_LEN [BAND_COUNT + 1] = '{
		4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd8,
		4'd9, 4'd10, 4'd11, 4'd12, 4'd14, 4'd15
	};

	// band index is the number of limits at or below h
	function automatic len_t band_lookup(input logic [6:0] h);
		logic [3:0] k;
		k = '0;
		for (int i = 0; i < BAND_COUNT; i++) begin
			k = k + 4'({7'd0, ({1'b0, h} >= BAND_LIMIT[i])});
		end
		return BAND_LEN[k];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dsp_if.sv -----
// ----------------------------------------------------------------------------
// dsp_evt_if / dsp_res_if
// Valid/ready channels for event words in and result words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsp_evt_if;
	logic            valid;
	logic            ready;
	dsp_pkg::op_t    op;
	logic [7:0]      sample;

	modport source (output valid, output op, output sample, input ready);
	modport sink   (input valid, input op, input sample, output ready);
endinterface

interface dsp_res_if;
	logic            valid;
	logic            ready;
	logic            pulse_a;
	logic            pulse_b;
	logic [7:0]      duty_a;
	logic [7:0]      duty_b;
	logic [1:0]      channel;

	modport source (output valid, output pulse_a, output pulse_b, output duty_a,
		output duty_b, output channel, input ready);
	modport sink   (input valid, input pulse_a, input pulse_b, input duty_a,
		input duty_b, input channel, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dual_servo_pulse_generator.sv -----
// ----------------------------------------------------------------------------
// dual_servo_pulse_generator
// Event-driven servo pulse controller: two duty registers, two software
// pulse pins and a four-channel converter rotation.
// ----------------------------------------------------------------------------
// Every event word gives exactly one result word showing the state after the
// event. A word is registered at the input, then applied to the state when
// the result register is free; the state registers are the result payload,
// so a result word holds while it waits. Result valid is registered and
// rises when the input register applies its word to the state; one word per
// cycle is sustained when the result side is ready. The duty offset is
// written through cfg_we/cfg_wdata (reset 124) and is read when an analog
// sample on channel 0 or 1 is applied.
`default_nettype none

module dual_servo_pulse_generator (
	input  wire         clk,
	input  wire         arst_n,
	dsp_evt_if.sink     evt,
	dsp_res_if.source   res,
	input  wire         cfg_we,
	input  wire [7:0]   cfg_wdata
);
	import dsp_pkg::*;

	duty_t  offset_q;
	logic   s1_valid_q;
	op_t    op_s1;
	logic [7:0] sample_s1;
	logic   res_valid_q;
	logic   advance;

	chan_t  chan_q, chan_d;
	duty_t  duty_a_q, duty_a_d, duty_b_q, duty_b_d;
	len_t   len_q [2];
	len_t   len_d [2];
	count_t count_q [2];
	count_t count_d [2];
	logic   en_q [2];
	logic   en_d [2];
	logic   pin_q [2];
	logic   pin_d [2];
	duty_t  duty_sum;
	len_t   band_len;

	assign advance   = s1_valid_q && (!res_valid_q || res.ready);
	assign evt.ready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= DUTY_OFFSET_RST;
		end else if (cfg_we) begin
			offset_q <= cfg_wdata;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (evt.ready) begin
			s1_valid_q <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			op_s1     <= evt.op;
			sample_s1 <= evt.sample;
		end
	end

	assign duty_sum = 8'({1'b0, sample_s1[7:1]} + offset_q);
	assign band_len = band_lookup(sample_s1[7:1]);

	always_comb begin
		chan_d   = chan_q;
		duty_a_d = duty_a_q;
		duty_b_d = duty_b_q;
		for (int i = 0; i < 2; i++) begin
			len_d[i]   = len_q[i];
			count_d[i] = count_q[i];
			en_d[i]    = en_q[i];
			pin_d[i]   = pin_q[i];
		end
		case (op_s1)
			OP_SAMPLE: begin
				unique case (chan_q)
					CHAN_DUTY_A: duty_a_d = duty_sum;
					CHAN_DUTY_B: duty_b_d = duty_sum;
					CHAN_LEN_A:  len_d[0] = band_len;
					CHAN_LEN_B:  len_d[1] = band_len;
					default:     duty_a_d = duty_a_q;
				endcase
				chan_d = chan_q + 2'd1;
			end
			OP_FAST_TICK: begin
				for (int i = 0; i < 2; i++) begin
					// end of pulse: drop the pin and stop counting
					if (count_q[i] == {4'd0, len_q[i]}) begin
						pin_d[i]   = 1'b0;
						en_d[i]    = 1'b0;
						count_d[i] = '0;
					end else if (en_q[i]) begin
						count_d[i] = count_q[i] + 8'd1;
					end
				end
			end
			OP_FRAME_TICK: begin
				for (int i = 0; i < 2; i++) begin
					en_d[i]  = 1'b1;
					pin_d[i] = 1'b1;
				end
			end
			default: begin
				chan_d = chan_q;
			end
		endcase
	end

	// state is the result payload; it only moves when the result register is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q   <= CHAN_DUTY_A;
			duty_a_q <= DUTY_RST;
			duty_b_q <= DUTY_RST;
			for (int i = 0; i < 2; i++) begin
				len_q[i]   <= '0;
				count_q[i] <= '0;
				en_q[i]    <= 1'b0;
				pin_q[i]   <= 1'b0;
			end
		end else if (advance) begin
			chan_q   <= chan_d;
			duty_a_q <= duty_a_d;
			duty_b_q <= duty_b_d;
			for (int i = 0; i < 2; i++) begin
				len_q[i]   <= len_d[i];
				count_q[i] <= count_d[i];
				en_q[i]    <= en_d[i];
				pin_q[i]   <= pin_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res.valid   = res_valid_q;
	assign res.pulse_a = pin_q[0];
	assign res.pulse_b = pin_q[1];
	assign res.duty_a  = duty_a_q;
	assign res.duty_b  = duty_b_q;
	assign res.channel = chan_q;

endmodule

`default_nettype wire

// ----- rtl/core/dsp_checker.sv -----
// ----------------------------------------------------------------------------
// dsp_checker
// Port-level checks on the result channel of the servo pulse generator.
// ----------------------------------------------------------------------------
`default_nettype none

module dsp_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       res_valid,
	input wire       res_ready,
	input wire       pulse_a,
	input wire       pulse_b,
	input wire [7:0] duty_a,
	input wire [7:0] duty_b,
	input wire [1:0] channel
);

	// hold a stalled result word
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(duty_a) && $stable(duty_b)
			&& $stable(channel) && $stable(pulse_a) && $stable(pulse_b))
		else $error("result word changed while stalled");

	// state only moves together with a new result word
	a_state_with_word: assert property (@(posedge clk) disable iff (!arst_n)
		!($stable(duty_a) && $stable(duty_b) && $stable(channel)
			&& $stable(pulse_a) && $stable(pulse_b)) |-> res_valid)
		else $error("state changed without a result word");

	// duty A loads only on a channel 0 sample
	a_duty_a_chan: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(duty_a) |-> channel == 2'd1 && $past(channel) == 2'd0)
		else $error("duty A changed outside channel 0");

	// pins rise only on a frame tick, which raises both
	a_pins_rise_together: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pulse_a) || $rose(pulse_b) |-> pulse_a && pulse_b && $stable(channel))
		else $error("pins did not rise together");

endmodule

bind dual_servo_pulse_generator dsp_checker u_dsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.pulse_a   (res.pulse_a),
	.pulse_b   (res.pulse_b),
	.duty_a    (res.duty_a),
	.duty_b    (res.duty_b),
	.channel   (res.channel)
);

`default_nettype wire

// ----- bench/tb_dual_servo_pulse_generator.sv -----
// ----------------------------------------------------------------------------
// tb_dual_servo_pulse_generator
// Self-checking bench for the event-driven servo pulse generator. Event
// words go in through the evt channel and every result word is compared
// field by field against an in-bench model of the rotation, duty registers
// and software pulse counters. The bench covers directed corners, counter
// overrun, back-pressure and random traffic under several duty offsets.
// ----------------------------------------------------------------------------
module tb_dual_servo_pulse_generator;
	timeunit 1ns;
	timeprecision 1ps;

	import dsp_pkg::*;

	// op code 3 is not an enum member; the block must ignore it
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int RX_ALWAYS  = 0;
	localparam int RX_LIGHT   = 1;
	localparam int RX_PATTERN = 2;
	localparam int RX_HEAVY   = 3;

	localparam int DRAIN_CYCLES = 6;
	localparam int STALL_LIMIT  = 3000;
	localparam int MAX_PRINTS   = 30;

	typedef struct packed {
		logic       pulse_a;
		logic       pulse_b;
		logic [7:0] duty_a;
		logic [7:0] duty_b;
		logic [1:0] channel;
	} servo_word_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [7:0] cfg_wdata;

	dsp_evt_if evt_if ();
	dsp_res_if res_if ();

	dual_servo_pulse_generator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt_if),
		.res       (res_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// model state
	logic [7:0] m_offset;
	logic [1:0] m_chan;
	logic [7:0] m_duty_a;
	logic [7:0] m_duty_b;
	logic [3:0] m_len [2];
	logic [7:0] m_count [2];
	logic       m_enable [2];
	logic       m_pin [2];

	servo_word_t pending_results [$];

	int n_errors;
	int n_checked;
	int n_sample, n_fast, n_frame, n_unused, n_offset_writes;
	int rx_mode;
	int rx_phase;
	int hold_off;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [3:0] pulse_len_for(input logic [6:0] h);
		if (h < 19) return 4'd2;
		else if (h < 40) return 4'd3;
		else if (h < 61) return 4'd5;
		else if (h < 82) return 4'd6;
		else if (h < 103) return 4'd7;
		else if (h < 131) return 4'd8;
		else if (h < 152) return 4'd9;
		else if (h < 173) return 4'd10;
		else if (h < 194) return 4'd11;
		else if (h < 215) return 4'd12;
		else if (h < 236) return 4'd14;
		else return 4'd15;
	endfunction

	task automatic reset_servo_model();
		m_offset = DUTY_OFFSET_RST;
		m_chan   = CHAN_DUTY_A;
		m_duty_a = DUTY_RST;
		m_duty_b = DUTY_RST;
		for (int i = 0; i < 2; i++) begin
			m_len[i]    = '0;
			m_count[i]  = '0;
			m_enable[i] = 1'b0;
			m_pin[i]    = 1'b0;
		end
	endtask

	task automatic apply_servo_event(input logic [1:0] code, input logic [7:0] smp);
		logic [6:0]  half;
		servo_word_t w;
		half = smp[7:1];
		case (code)
			OP_SAMPLE: begin
				case (m_chan)
					CHAN_DUTY_A: m_duty_a = 8'({1'b0, half} + m_offset);
					CHAN_DUTY_B: m_duty_b = 8'({1'b0, half} + m_offset);
					CHAN_LEN_A:  m_len[0] = pulse_len_for(half);
					default:     m_len[1] = pulse_len_for(half);
				endcase
				m_chan = m_chan + 2'd1;
				n_sample++;
			end
			OP_FAST_TICK: begin
				for (int i = 0; i < 2; i++) begin
					if (m_count[i] == {4'd0, m_len[i]}) begin
						m_pin[i]    = 1'b0;
						m_enable[i] = 1'b0;
						m_count[i]  = '0;
					end
					if (m_enable[i])
						m_count[i] = m_count[i] + 8'd1;
				end
				n_fast++;
			end
			OP_FRAME_TICK: begin
				for (int i = 0; i < 2; i++) begin
					m_enable[i] = 1'b1;
					m_pin[i]    = 1'b1;
				end
				n_frame++;
			end
			default: n_unused++;
		endcase
		w.pulse_a = m_pin[0];
		w.pulse_b = m_pin[1];
		w.duty_a  = m_duty_a;
		w.duty_b  = m_duty_b;
		w.channel = m_chan;
		pending_results.push_back(w);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		if (n_errors < MAX_PRINTS)
			$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		n_errors++;
	endtask

	// hold valid high across back-to-back words; lower it only in gaps
	task automatic send_word(input logic [1:0] code, input logic [7:0] smp);
		@(negedge clk);
		evt_if.valid  = 1'b1;
		evt_if.op     = op_t'(code);
		evt_if.sample = smp;
		do @(posedge clk); while (!evt_if.ready);
		apply_servo_event(code, smp);
	endtask

	task automatic idle_gap(input int n);
		if (n > 0) begin
			@(negedge clk);
			evt_if.valid = 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_drain();
		@(negedge clk);
		evt_if.valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_duty_offset(input logic [7:0] value);
		wait_drain();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we    = 1'b0;
		m_offset  = value;
		n_offset_writes++;
	endtask

	// feed dummy samples until the rotation reaches chan, then load it
	task automatic load_channel(input logic [1:0] chan, input logic [7:0] smp);
		while (m_chan != chan) send_word(OP_SAMPLE, 8'($urandom));
		send_word(OP_SAMPLE, smp);
	endtask

	function automatic logic [1:0] random_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) return OP_SAMPLE;
		else if (r < 75) return OP_FAST_TICK;
		else if (r < 92) return OP_FRAME_TICK;
		else return OP_UNUSED;
	endfunction

	function automatic logic [7:0] random_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 8'd0;
		else if (r == 1) return 8'd255;
		else return 8'($urandom);
	endfunction

	// receiver stall pattern
	always @(negedge clk) begin
		if (hold_off > 0) begin
			res_if.ready = 1'b0;
			hold_off--;
		end else begin
			case (rx_mode)
				RX_ALWAYS: res_if.ready = 1'b1;
				RX_LIGHT:  res_if.ready = ($urandom_range(0, 3) != 0);
				RX_PATTERN: begin
					res_if.ready = (rx_phase < 3);
					rx_phase = (rx_phase == 4) ? 0 : rx_phase + 1;
				end
				default:   res_if.ready = ($urandom_range(0, 9) < 4);
			endcase
		end
	end

	// result checker
	always @(posedge clk) begin
		servo_word_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result word", 1, 0);
			end else begin
				want = pending_results.pop_front();
				if (res_if.pulse_a !== want.pulse_a)
					report_mismatch("pulse_a", res_if.pulse_a, want.pulse_a);
				if (res_if.pulse_b !== want.pulse_b)
					report_mismatch("pulse_b", res_if.pulse_b, want.pulse_b);
				if (res_if.duty_a !== want.duty_a)
					report_mismatch("duty_a", res_if.duty_a, want.duty_a);
				if (res_if.duty_b !== want.duty_b)
					report_mismatch("duty_b", res_if.duty_b, want.duty_b);
				if (res_if.channel !== want.channel)
					report_mismatch("channel", res_if.channel, want.channel);
				n_checked++;
			end
		end
	end

	// watchdog: cycles with no word moving on either side
	always @(posedge clk) begin
		if ((evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	task automatic test_reset_state();
		rx_mode = RX_ALWAYS;
		send_word(OP_UNUSED, 8'hff);
		// length zero: the first fast tick after a frame drops the pin
		send_word(OP_FAST_TICK, 8'h00);
		send_word(OP_FRAME_TICK, 8'haa);
		send_word(OP_FAST_TICK, 8'h55);
		send_word(OP_UNUSED, 8'h00);
		wait_drain();
	endtask

	task automatic test_duty_and_bands();
		rx_mode = RX_LIGHT;
		write_duty_offset(8'd0);
		send_word(OP_SAMPLE, 8'd0);
		send_word(OP_SAMPLE, 8'd255);
		send_word(OP_SAMPLE, 8'd0);
		send_word(OP_SAMPLE, 8'd255);
		write_duty_offset(8'd255);
		send_word(OP_SAMPLE, 8'd255);
		send_word(OP_SAMPLE, 8'd2);
		// band edges on both length channels
		send_word(OP_SAMPLE, 8'd37);
		send_word(OP_SAMPLE, 8'd38);
		load_channel(CHAN_LEN_A, 8'd78);
		send_word(OP_SAMPLE, 8'd80);
		load_channel(CHAN_LEN_A, 8'd120);
		send_word(OP_SAMPLE, 8'd122);
		load_channel(CHAN_LEN_A, 8'd162);
		send_word(OP_SAMPLE, 8'd164);
		load_channel(CHAN_LEN_A, 8'd204);
		send_word(OP_SAMPLE, 8'd206);
		wait_drain();
	endtask

	task automatic test_pulse_timing();
		rx_mode = RX_PATTERN;
		load_channel(CHAN_LEN_A, 8'd0);
		send_word(OP_SAMPLE, 8'd100);
		send_word(OP_FRAME_TICK, 8'($urandom));
		for (int i = 0; i < 9; i++) send_word(OP_FAST_TICK, 8'($urandom));
		// frame in the middle of a running pulse keeps the counts
		send_word(OP_FRAME_TICK, 8'($urandom));
		send_word(OP_FAST_TICK, 8'($urandom));
		send_word(OP_FRAME_TICK, 8'($urandom));
		for (int i = 0; i < 8; i++) send_word(OP_FAST_TICK, 8'($urandom));
		wait_drain();
	endtask

	task automatic test_counter_overrun();
		rx_mode = RX_LIGHT;
		load_channel(CHAN_LEN_A, 8'd206);
		send_word(OP_SAMPLE, 8'd255);
		send_word(OP_FRAME_TICK, 8'd0);
		for (int i = 0; i < 5; i++) send_word(OP_FAST_TICK, 8'($urandom));
		// shrink both lengths below the running counts
		load_channel(CHAN_LEN_A, 8'd0);
		send_word(OP_SAMPLE, 8'd1);
		for (int i = 0; i < 262; i++) begin
			send_word(OP_FAST_TICK, 8'($urandom));
			if ($urandom_range(0, 15) == 0) idle_gap($urandom_range(1, 4));
		end
		wait_drain();
	endtask

	task automatic test_backpressure();
		rx_mode  = RX_ALWAYS;
		hold_off = 150;
		for (int i = 0; i < 60; i++) send_word(random_op(), random_sample());
		wait_drain();
	endtask

	task automatic run_random_phase(input int items, input int mode);
		int sent;
		int burst;
		rx_mode = mode;
		sent = 0;
		while (sent < items) begin
			burst = $urandom_range(1, 32);
			for (int i = 0; i < burst; i++) send_word(random_op(), random_sample());
			sent += burst;
			if ($urandom_range(0, 9) == 0)
				wait_drain();
			else if ($urandom_range(0, 3) != 0)
				idle_gap($urandom_range(1, 6));
		end
	endtask

	task automatic test_random_traffic();
		run_random_phase(220, RX_ALWAYS);
		write_duty_offset(8'd0);
		run_random_phase(220, RX_LIGHT);
		write_duty_offset(8'd255);
		run_random_phase(220, RX_PATTERN);
		write_duty_offset(8'($urandom));
		run_random_phase(220, RX_HEAVY);
		write_duty_offset(8'd128);
		run_random_phase(220, RX_LIGHT);
		write_duty_offset(DUTY_OFFSET_RST);
		run_random_phase(220, RX_ALWAYS);
		wait_drain();
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		evt_if.valid  = 1'b0;
		evt_if.op     = OP_SAMPLE;
		evt_if.sample = '0;
		res_if.ready  = 1'b0;
		rx_mode       = RX_ALWAYS;
		rx_phase      = 0;
		hold_off      = 0;
		idle_cycles   = 0;
		n_errors      = 0;
		n_checked     = 0;
		n_sample      = 0;
		n_fast        = 0;
		n_frame       = 0;
		n_unused      = 0;
		n_offset_writes = 0;
		reset_servo_model();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_duty_and_bands();
		test_pulse_timing();
		test_counter_overrun();
		test_backpressure();
		test_random_traffic();

		wait_drain();
		repeat (10) @(posedge clk);
		$display("covered %0d samples, %0d fast ticks, %0d frame ticks, %0d unused codes",
			n_sample, n_fast, n_frame, n_unused);
		$display("%0d result words checked over %0d duty offset writes, %0d mismatches",
			n_checked, n_offset_writes, n_errors);
		if (n_errors == 0 && pending_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/dsp_pkg.sv
rtl/core/dsp_if.sv
rtl/core/dual_servo_pulse_generator.sv
rtl/core/dsp_checker.sv
bench/tb_dual_servo_pulse_generator.sv
